/* rtl/bafan_pkg.sv */
// Shared types and constants for the block-average fan thermostat.
`timescale 1ns / 1ps

package bafan_pkg;

    localparam int MAX_BLOCK  = 255;

    localparam int TEMP_W     = 11;
    localparam int HUM_W      = 10;
    localparam int CNT_W      = 8;
    localparam int TSUM_W     = 19;
    localparam int HSUM_W     = 18;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // Divider works on the magnitude of a sum: 19 bits covers |-2^18|.
    localparam int DIV_W      = 19;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT   = 1'b1;

    localparam logic [CNT_W-1:0]      BLOCK_LENGTH_RST = 8'd10;
    localparam logic [TEMP_W-1:0]     TEMP_LIMIT_RST   = 11'sd300;

    localparam logic signed [TSUM_W-1:0] TSUM_MAX = 19'sh3FFFF;
    localparam logic signed [TSUM_W-1:0] TSUM_MIN = 19'sh40000;
    localparam logic [HSUM_W-1:0]        HSUM_MAX = 18'h3FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/block_average_fan_thermostat_unit.sv */
// Top level: block accumulation, averaging sequencer and fan decision.
//
//  port group   dir  fields (lsb first)
//  s_axis       in   tdata: temperature[10:0], humidity[20:11]; tuser: reading_ok
//  m_axis       out  tdata: avg_temperature, avg_humidity, valid_count,
//                    reading_count, fan_on, fan_changed; tuser: report, no_valid_data
//  cfg          in   0 block_length, 1 temp_limit; write-only
//
//  A word that does not close a non-empty block passes through S_EVAL and S_OUT before the
//  next word is accepted, and is loaded into the output register from S_OUT.
//  A word that closes a non-empty block also passes S_DIVT and S_DIVH: the shared serial
//  divider works out the temperature average first, then the humidity average.
//  tready is low while the sequencer works, and also while a finished word waits for a
//  stalled m_axis to free the output register; one word can wait there while the next
//  is worked on. Reset: synchronous active low, sums and counters zero, fan off.
`timescale 1ns / 1ps

module block_average_fan_thermostat_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // cfg
    input  logic                                  i_cfg_we,
    input  logic [bafan_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bafan_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [23:0]                           i_s_axis_tdata,  // temperature, humidity
    input  logic                                  i_s_axis_tuser,  // reading_ok
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // avg_temperature, avg_humidity, valid_count, reading_count, fan_on, fan_changed
    output logic [39:0]                           o_m_axis_tdata,
    output logic [1:0]                            o_m_axis_tuser   // report, no_valid_data
);

    localparam int CW = bafan_pkg::CNT_W;
    localparam int TW = bafan_pkg::TEMP_W;
    localparam int HW = bafan_pkg::HUM_W;
    localparam int SW = bafan_pkg::TSUM_W;
    localparam int UW = bafan_pkg::HSUM_W;
    localparam int DW = bafan_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIVT,
        S_DIVH,
        S_OUT
    } t_state;

    t_state                  r_state;

    logic [CW-1:0]           r_block_length;
    logic signed [TW-1:0]    r_temp_limit;

    logic [CW-1:0]           r_block_cnt;
    logic [CW-1:0]           r_valid_cnt;
    logic signed [SW-1:0]    r_temp_sum;
    logic [UW-1:0]           r_hum_sum;
    logic signed [TW-1:0]    r_temp_avg;
    logic [HW-1:0]           r_hum_avg;
    logic                    r_fan;
    logic                    r_changed;
    logic                    r_report;
    logic                    r_empty;
    logic                    r_end;

    logic                    r_out_valid;
    logic [39:0]             r_out_data;
    logic [1:0]              r_out_user;

    // accept-cycle datapath
    logic                    accept;
    logic                    ok;
    logic signed [TW-1:0]    temp_in;
    logic [HW-1:0]           hum_in;
    logic [CW-1:0]           len_eff;
    logic                    clr;
    logic [CW-1:0]           base_bc;
    logic [CW-1:0]           base_vc;
    logic signed [SW-1:0]    base_ts;
    logic [UW-1:0]           base_hs;
    logic [CW-1:0]           n_block_cnt;
    logic [CW-1:0]           n_valid_cnt;
    logic signed [SW:0]      tsum_wide;
    logic signed [SW-1:0]    n_temp_sum;
    logic [UW:0]             hsum_wide;
    logic [UW-1:0]           n_hum_sum;

    // divider hookup
    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    bafan_pkg::t_div_stat    div_stat;
    logic [DW-1:0]           div_quo;
    logic [DW-1:0]           quo_signed;
    logic                    fan_next;
    logic                    out_free;

    assign ok      = i_s_axis_tuser;
    assign temp_in = i_s_axis_tdata[TW-1:0];
    assign hum_in  = i_s_axis_tdata[TW+HW-1:TW];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        len_eff = r_block_length;
        if (len_eff == '0)
            len_eff = CW'(1);
        if (len_eff > CW'(bafan_pkg::MAX_BLOCK))
            len_eff = CW'(bafan_pkg::MAX_BLOCK);
    end

    // previous block complete: start from a clean slate
    assign clr     = r_block_cnt >= len_eff;
    assign base_bc = clr ? '0 : r_block_cnt;
    assign base_vc = clr ? '0 : r_valid_cnt;
    assign base_ts = clr ? '0 : r_temp_sum;
    assign base_hs = clr ? '0 : r_hum_sum;

    assign n_block_cnt = base_bc + 1'b1;
    assign tsum_wide   = {base_ts[SW-1], base_ts} + (SW+1)'(temp_in);
    assign hsum_wide   = {1'b0, base_hs} + (UW+1)'(hum_in);

    always_comb begin
        n_valid_cnt = base_vc;
        n_temp_sum  = base_ts;
        n_hum_sum   = base_hs;
        if (ok) begin
            if (base_vc != {CW{1'b1}})
                n_valid_cnt = base_vc + 1'b1;
            if (tsum_wide > (SW+1)'(bafan_pkg::TSUM_MAX))
                n_temp_sum = bafan_pkg::TSUM_MAX;
            else if (tsum_wide < (SW+1)'(bafan_pkg::TSUM_MIN))
                n_temp_sum = bafan_pkg::TSUM_MIN;
            else
                n_temp_sum = tsum_wide[SW-1:0];
            n_hum_sum = hsum_wide[UW] ? bafan_pkg::HSUM_MAX : hsum_wide[UW-1:0];
        end
    end

    // divider takes magnitudes; the sign is put back on the quotient
    assign div_start    = (r_state == S_EVAL && r_end && r_valid_cnt != '0)
                       || (r_state == S_DIVT && div_stat.done);
    assign div_dividend = (r_state == S_EVAL)
                        ? (r_temp_sum[SW-1] ? DW'(-r_temp_sum) : DW'(r_temp_sum))
                        : DW'(r_hum_sum);
    assign quo_signed   = r_temp_sum[SW-1] ? -div_quo : div_quo;
    assign fan_next     = r_temp_avg >= r_temp_limit;

    bafan_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_valid_cnt),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_block_length <= bafan_pkg::BLOCK_LENGTH_RST;
            r_temp_limit   <= bafan_pkg::TEMP_LIMIT_RST;
            r_block_cnt    <= '0;
            r_valid_cnt    <= '0;
            r_temp_sum     <= '0;
            r_hum_sum      <= '0;
            r_temp_avg     <= '0;
            r_hum_avg      <= '0;
            r_fan          <= 1'b0;
            r_changed      <= 1'b0;
            r_report       <= 1'b0;
            r_empty        <= 1'b0;
            r_end          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bafan_pkg::CFG_BLOCK_LENGTH: r_block_length <= i_cfg_data[CW-1:0];
                    bafan_pkg::CFG_TEMP_LIMIT:   r_temp_limit   <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            // output register: loaded by the sequencer, otherwise cleared once taken
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_axis_tready)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_block_cnt <= n_block_cnt;
                        r_valid_cnt <= n_valid_cnt;
                        r_temp_sum  <= n_temp_sum;
                        r_hum_sum   <= n_hum_sum;
                        r_end       <= (n_block_cnt == len_eff);
                        r_changed   <= 1'b0;
                        r_report    <= 1'b0;
                        r_empty     <= 1'b0;
                        r_state     <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_end && r_valid_cnt != '0) begin
                        r_state <= S_DIVT;
                    end else begin
                        r_empty <= r_end;
                        r_state <= S_OUT;
                    end
                end
                S_DIVT: begin
                    if (div_stat.done) begin
                        r_temp_avg <= quo_signed[TW-1:0];
                        r_state    <= S_DIVH;
                    end
                end
                S_DIVH: begin
                    if (div_stat.done) begin
                        r_hum_avg <= div_quo[HW-1:0];
                        r_fan     <= fan_next;
                        r_changed <= (fan_next != r_fan);
                        r_report  <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {1'b0, r_changed, r_fan, r_block_cnt, r_valid_cnt,
                           r_hum_avg, r_temp_avg};
            r_out_user <= {r_empty, r_report};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

/* rtl/bafan_div.sv */
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bafan_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bafan_pkg::DIV_W-1:0]    i_dividend,
    input  logic [bafan_pkg::CNT_W-1:0]    i_divisor,
    output bafan_pkg::t_div_stat           o_stat,
    output logic [bafan_pkg::DIV_W-1:0]    o_quotient
);

    logic [bafan_pkg::DIV_W-1:0]     r_quo;
    logic [bafan_pkg::CNT_W-1:0]     r_rem;
    logic [bafan_pkg::CNT_W-1:0]     r_div;
    logic [bafan_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            r_done;

    logic [bafan_pkg::CNT_W:0]       shifted;
    logic [bafan_pkg::CNT_W:0]       diff;
    logic                            fits;

    assign shifted = {r_rem, r_quo[bafan_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= bafan_pkg::DIV_CNT_W'(bafan_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bafan_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 8 bits hold it
            r_rem <= fits ? diff[bafan_pkg::CNT_W-1:0] : shifted[bafan_pkg::CNT_W-1:0];
            r_quo <= {r_quo[bafan_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

/* tb/bafan_result_checker.sv */
// Checker for the block-average fan thermostat: predicts each output word and compares it.
`timescale 1ns / 1ps

module bafan_result_checker
    import bafan_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // temperature, humidity
    input  logic                  i_s_axis_tuser,  // reading_ok
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // avg_temperature, avg_humidity, valid_count, reading_count, fan_on, fan_changed
    input  logic [39:0]           i_m_axis_tdata,
    input  logic [1:0]            i_m_axis_tuser,  // report, no_valid_data
    output int                    o_fail_count,
    output int                    o_words_in_flight
);

    typedef struct {
        logic                     report;
        logic                     empty;
        logic signed [TEMP_W-1:0] avg_temp;
        logic [HUM_W-1:0]         avg_hum;
        logic [CNT_W-1:0]         valid_cnt;
        logic [CNT_W-1:0]         read_cnt;
        logic                     fan_on;
        logic                     fan_changed;
    } t_readout;

    // mirrored configuration
    logic [CNT_W-1:0]         span_reg  = BLOCK_LENGTH_RST;
    logic signed [TEMP_W-1:0] limit_reg = TEMP_LIMIT_RST;

    // mirrored block state
    int unsigned              readings  = 0;
    int unsigned              good      = 0;
    int                       temp_acc  = 0;
    int unsigned              hum_acc   = 0;
    logic signed [TEMP_W-1:0] temp_mean = '0;
    logic [HUM_W-1:0]         hum_mean  = '0;
    logic                     fan       = 1'b0;

    t_readout expected_readouts[$];
    int       mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0t %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Advances the block by one reading and returns the word it should produce.
    function automatic t_readout advance_block_average(input logic ok,
                                                       input logic signed [TEMP_W-1:0] temp,
                                                       input logic [HUM_W-1:0] hum);
        t_readout    r;
        int unsigned span;
        int          s;
        logic        next_fan;
        span = (span_reg == 0) ? 1 : span_reg;
        r.report      = 1'b0;
        r.empty       = 1'b0;
        r.fan_changed = 1'b0;
        // previous block done: start over before counting this one
        if (readings >= span) begin
            readings = 0;
            good     = 0;
            temp_acc = 0;
            hum_acc  = 0;
        end
        readings++;
        if (ok) begin
            if (good < 255)
                good++;
            s = temp_acc + int'(temp);
            if (s > 262143)
                s = 262143;
            if (s < -262144)
                s = -262144;
            temp_acc = s;
            hum_acc  = hum_acc + hum;
            if (hum_acc > 262143)
                hum_acc = 262143;
        end
        if (readings == span) begin
            if (good == 0) begin
                r.empty = 1'b1;
            end else begin
                r.report  = 1'b1;
                temp_mean = TEMP_W'(temp_acc / int'(good));   // truncates toward zero
                hum_mean  = HUM_W'(hum_acc / good);
                next_fan  = (temp_mean >= limit_reg);
                r.fan_changed = (next_fan != fan);
                fan = next_fan;
            end
        end
        r.avg_temp  = temp_mean;
        r.avg_hum   = hum_mean;
        r.valid_cnt = CNT_W'(good);
        r.read_cnt  = CNT_W'(readings);
        r.fan_on    = fan;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_readout got;
        t_readout want;
        logic     s_take;
        logic     m_take;
        s_take = i_s_axis_tvalid && i_s_axis_tready;
        m_take = i_m_axis_tvalid && i_m_axis_tready;
        if (!i_rst_n) begin
            span_reg  = BLOCK_LENGTH_RST;
            limit_reg = TEMP_LIMIT_RST;
            readings  = 0;
            good      = 0;
            temp_acc  = 0;
            hum_acc   = 0;
            temp_mean = '0;
            hum_mean  = '0;
            fan       = 1'b0;
            expected_readouts.delete();
            o_words_in_flight <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCK_LENGTH: span_reg  = i_cfg_data[CNT_W-1:0];
                    CFG_TEMP_LIMIT:   limit_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_take)
                expected_readouts.push_back(advance_block_average(i_s_axis_tuser,
                    i_s_axis_tdata[10:0], i_s_axis_tdata[20:11]));
            if (m_take) begin
                got.avg_temp    = i_m_axis_tdata[10:0];
                got.avg_hum     = i_m_axis_tdata[20:11];
                got.valid_cnt   = i_m_axis_tdata[28:21];
                got.read_cnt    = i_m_axis_tdata[36:29];
                got.fan_on      = i_m_axis_tdata[37];
                got.fan_changed = i_m_axis_tdata[38];
                got.report      = i_m_axis_tuser[0];
                got.empty       = i_m_axis_tuser[1];
                if (expected_readouts.size() == 0) begin
                    note_mismatch("unexpected output word", 1, 0);
                end else begin
                    want = expected_readouts.pop_front();
                    if (got.report != want.report)
                        note_mismatch("report", got.report, want.report);
                    if (got.empty != want.empty)
                        note_mismatch("no_valid_data", got.empty, want.empty);
                    if (got.avg_temp != want.avg_temp)
                        note_mismatch("avg_temperature", got.avg_temp, want.avg_temp);
                    if (got.avg_hum != want.avg_hum)
                        note_mismatch("avg_humidity", got.avg_hum, want.avg_hum);
                    if (got.valid_cnt != want.valid_cnt)
                        note_mismatch("valid_count", got.valid_cnt, want.valid_cnt);
                    if (got.read_cnt != want.read_cnt)
                        note_mismatch("reading_count", got.read_cnt, want.read_cnt);
                    if (got.fan_on != want.fan_on)
                        note_mismatch("fan_on", got.fan_on, want.fan_on);
                    if (got.fan_changed != want.fan_changed)
                        note_mismatch("fan_changed", got.fan_changed, want.fan_changed);
                end
            end
            o_words_in_flight <= o_words_in_flight + int'(s_take) - int'(m_take);
        end
    end

endmodule

/* tb/tb_block_average_fan_thermostat_unit.sv */
// Testbench top for the block-average fan thermostat: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_block_average_fan_thermostat_unit;
    import bafan_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int LONG_HOLD  = 200;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata  = '0;  // temperature, humidity
    logic                  i_s_axis_tuser  = 1'b0; // reading_ok
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // avg_temperature, avg_humidity, valid_count, reading_count, fan_on, fan_changed
    logic [39:0]           o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;         // report, no_valid_data

    logic gaps_on    = 1'b1;
    logic stalls_on  = 1'b1;
    int   hold_asks  = 0;
    int   holds_done = 0;
    int   limit_now  = 300;
    int   fail_count;
    int   words_in_flight;

    block_average_fan_thermostat_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    bafan_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_s_axis_tvalid   (i_s_axis_tvalid),
        .i_s_axis_tready   (o_s_axis_tready),
        .i_s_axis_tdata    (i_s_axis_tdata),
        .i_s_axis_tuser    (i_s_axis_tuser),
        .i_m_axis_tvalid   (o_m_axis_tvalid),
        .i_m_axis_tready   (i_m_axis_tready),
        .i_m_axis_tdata    (o_m_axis_tdata),
        .i_m_axis_tuser    (o_m_axis_tuser),
        .o_fail_count      (fail_count),
        .o_words_in_flight (words_in_flight)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog: a run that outlasts this timeout is reported as failed
    initial begin
        #(CLK_PERIOD * 600_000);
        $display("Verification failed");
        $finish;
    end

    // output side: short random stalls, plus a long hold-off whenever one is asked for
    initial begin : result_sink
        int n;
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_asks) begin
                holds_done++;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 4);
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // drop tvalid, then wait until every word sent has come back out
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_in_flight != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int span, input int limit);
        wait_drained();
        write_reg(CFG_BLOCK_LENGTH, span);
        write_reg(CFG_TEMP_LIMIT, limit);
        limit_now = limit;
    endtask

    // leaves tvalid high at the accepting edge; the next call or wait_drained handles it
    task automatic send_reading(input logic ok, input int temp, input int hum);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= ok;
        i_s_axis_tdata  <= {3'b000, HUM_W'(hum), TEMP_W'(temp)};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_batch(input int count, input int ok_pct);
        int   temp;
        int   hum;
        logic ok;
        repeat (count) begin
            ok = ($urandom_range(0, 99) < ok_pct);
            case ($urandom_range(0, 3))
                0: temp = int'($urandom_range(0, 1200)) - 400;
                1: temp = $urandom_range(0, 1) ? 800 : -400;
                default: begin
                    // hover around the threshold so the fan keeps toggling
                    temp = limit_now + int'($urandom_range(0, 80)) - 40;
                    if (temp > 800)
                        temp = 800;
                    if (temp < -400)
                        temp = -400;
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                hum = $urandom_range(0, 1) ? 1000 : 0;
            else
                hum = $urandom_range(0, 1000);
            send_reading(ok, temp, hum);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: ten readings, fan stays off
        send_reading(1'b1, -400, 0);
        send_reading(1'b1, 800, 1000);
        send_reading(1'b0, -400, 1000);
        send_reading(1'b1, 0, 0);
        send_reading(1'b1, -1, 1);
        send_reading(1'b1, 799, 999);
        send_reading(1'b1, -399, 500);
        send_reading(1'b0, 800, 0);
        send_reading(1'b1, 300, 1000);
        send_reading(1'b1, 512, 512);
        // block with no valid reading
        configure(2, 300);
        send_reading(1'b0, 500, 700);
        send_reading(1'b0, -200, 300);
        // average exactly at the top limit turns the fan on
        configure(3, 800);
        repeat (3) send_reading(1'b1, 800, 1000);
        // negative average truncates toward zero, fan stays on at the lowest limit
        configure(2, -400);
        send_reading(1'b1, -400, 0);
        send_reading(1'b1, -399, 0);
        configure(1, 800);
        send_reading(1'b1, 799, 3);
        // shorten the block while three readings are already counted
        configure(5, 300);
        send_reading(1'b1, 100, 100);
        send_reading(1'b1, 200, 200);
        send_reading(1'b1, 300, 300);
        configure(2, 300);
        send_reading(1'b1, 400, 400);
        send_reading(1'b1, -300, 0);
        // zero length acts as one
        configure(0, 300);
        send_reading(1'b1, 350, 10);

        configure(1, -400);
        send_batch(100, 70);
        configure(2, 800);
        hold_asks++;
        send_batch(100, 50);
        configure(3, int'($urandom_range(0, 1200)) - 400);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_batch(150, 90);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        configure(255, 300);
        send_batch(270, 95);
        configure(0, int'($urandom_range(0, 1200)) - 400);
        send_batch(80, 60);
        configure(5, int'($urandom_range(0, 1200)) - 400);
        send_batch(150, 30);
        configure($urandom_range(1, 16), int'($urandom_range(0, 1200)) - 400);
        hold_asks++;
        send_batch(150, 85);
        // closing stretch without idling
        configure(4, int'($urandom_range(0, 1200)) - 400);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_batch(200, 90);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && words_in_flight == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
